@@ rtl/usb_descriptor_tree_walker_top_assert.svh @@
// assertion macros for the descriptor tree walker
`ifndef USB_DESCRIPTOR_TREE_WALKER_TOP_ASSERT_SVH
`define USB_DESCRIPTOR_TREE_WALKER_TOP_ASSERT_SVH

// condition holds whenever out of reset
`define UDTW_ASSERT_ALWAYS(label, ck, rs, cond) \
  label: assert property (@(posedge ck) disable iff (rs) (cond)) \
    else $error("udtw check failed");

// antecedent implies consequent in the same cycle
`define UDTW_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("udtw check failed");

// antecedent implies consequent in the next cycle
`define UDTW_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("udtw check failed");

`endif

@@ rtl/udtw_pkg.sv @@
package udtw_pkg;

  localparam int PAIR_REGS   = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int MAX_DEPTH_DEF    = 8;
  localparam int NEST_ENTRIES_DEF = 6;
  localparam int BUFFER_BYTES_DEF = 65535;

  localparam logic [CFG_INDEX_W-1:0] REG_NEST_PAIR_A = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NEST_PAIR_B = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NEST_PAIR_C = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NEST_PAIR_D = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NEST_PAIR_E = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_NEST_PAIR_F = 3'd5;

  localparam logic [CFG_DATA_W-1:0] PAIR_RESET [PAIR_REGS] = '{
    16'h0204, 16'h0405, 16'h0530, 16'h0429, 16'h0421, 16'h2122
  };

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_TYPE = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_ZERO_LEN = 2'd1,
    FAULT_TOO_DEEP = 2'd2,
    FAULT_TOO_LONG = 2'd3
  } fault_t;

  typedef struct packed {
    logic        visit;
    logic [15:0] desc_offset;
    logic [3:0]  nest_depth;
    logic [7:0]  desc_type;
    logic        walk_done;
    fault_t      fault;
  } result_t;

endpackage

@@ rtl/usb_descriptor_tree_walker_top.sv @@
// descriptor tree walker: takes a descriptor buffer one byte per transfer on the
// input channel (data_byte, last_byte; in_valid / in_stall) and returns one result
// per byte on the output channel (visit, desc_offset, nest_depth, desc_type,
// walk_done, fault; out_valid / out_stall).
// a result is registered in the result register, or in the skid register if that one waits.
// throughput: one byte per cycle while in_stall is low; the ancestor stack is compared
// against the nesting table in parallel, so the single pass of logic between the byte
// and the result register sets the rate.
// a two-entry output buffer (result register plus skid register) lets a byte be
// taken while the previous result waits; in_stall rises only once the skid
// register holds a result, and drops the cycle after the receiver drains it.
// the user must write the nesting table through cfg_we / cfg_index / cfg_data only while the
// walker is idle, which the block itself does not enforce; indexes beyond the table are ignored.
// reset loads the default table, clears the walk state and empties the output
// buffer; after a byte marked last the walk state returns to its reset values.
module usb_descriptor_tree_walker_top
  import udtw_pkg::*;
#(
  parameter int MAX_DEPTH    = MAX_DEPTH_DEF,
  parameter int NEST_ENTRIES = NEST_ENTRIES_DEF,
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   visit,
  output logic [15:0]            desc_offset,
  output logic [3:0]             nest_depth,
  output logic [7:0]             desc_type,
  output logic                   walk_done,
  output logic [1:0]             fault
);

  localparam int DW     = $clog2(MAX_DEPTH + 1);
  localparam int USED   = (NEST_ENTRIES < PAIR_REGS) ? NEST_ENTRIES : PAIR_REGS;
  localparam logic [15:0] BUF_LIMIT = 16'(BUFFER_BYTES);

  logic [CFG_DATA_W-1:0] nest_pair [PAIR_REGS];

  logic [15:0]   byte_position, byte_position_next;
  logic [15:0]   next_start, next_start_next;
  logic [15:0]   cur_start, cur_start_next;
  phase_t        byte_phase, byte_phase_next;
  logic [DW-1:0] top_depth, top_depth_next;
  logic          ended_flag, ended_flag_next;
  logic [7:0]    anc [MAX_DEPTH+1];
  logic          anc_we;
  logic [DW-1:0] anc_wa;

  logic [USED-1:0]      child_ok;
  logic [MAX_DEPTH:0]   hit;
  logic                 any_hit;
  logic [DW-1:0]        found;
  logic [16:0]          len_sum;

  result_t res;
  result_t out_q, skid_q;
  logic    skid_valid;
  logic    accept, take;

  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;
  assign in_stall = skid_valid;

  // nesting table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PAIR_REGS; k++) begin
        nest_pair[k] <= PAIR_RESET[k];
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NEST_PAIR_A: nest_pair[0] <= cfg_data;
        REG_NEST_PAIR_B: nest_pair[1] <= cfg_data;
        REG_NEST_PAIR_C: nest_pair[2] <= cfg_data;
        REG_NEST_PAIR_D: nest_pair[3] <= cfg_data;
        REG_NEST_PAIR_E: nest_pair[4] <= cfg_data;
        REG_NEST_PAIR_F: nest_pair[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // table entries up to the first zero byte, matched against the incoming type
  always_comb begin
    logic live;
    live = 1'b1;
    for (int k = 0; k < USED; k++) begin
      live        = live && (nest_pair[k][15:8] != 8'd0) && (nest_pair[k][7:0] != 8'd0);
      child_ok[k] = live && (nest_pair[k][7:0] == data_byte);
    end
  end

  // every live stack level checked at once; deepest hit wins
  always_comb begin
    hit   = '0;
    found = '0;
    for (int i = 0; i <= MAX_DEPTH; i++) begin
      for (int k = 0; k < USED; k++) begin
        if (child_ok[k] && (nest_pair[k][15:8] == anc[i]) && (i <= int'(top_depth))) begin
          hit[i] = 1'b1;
        end
      end
    end
    for (int i = 0; i <= MAX_DEPTH; i++) begin
      if (hit[i]) begin
        found = DW'(i);
      end
    end
  end

  assign any_hit = |hit;
  assign len_sum = {1'b0, byte_position} + {9'd0, data_byte};

  always_comb begin
    byte_position_next = byte_position;
    next_start_next    = next_start;
    cur_start_next     = cur_start;
    byte_phase_next    = byte_phase;
    top_depth_next     = top_depth;
    ended_flag_next    = ended_flag;
    anc_we             = 1'b0;
    anc_wa             = '0;
    res                = '0;
    res.fault          = FAULT_NONE;
    if (accept) begin
      if (!ended_flag) begin
        if (byte_position >= BUF_LIMIT) begin
          res.fault       = FAULT_TOO_LONG;
          ended_flag_next = 1'b1;
        end else begin
          if (byte_phase == PH_TYPE) begin
            byte_phase_next = PH_BODY;
            if (cur_start == 16'd0) begin
              // root descriptor
              anc_we         = 1'b1;
              anc_wa         = '0;
              top_depth_next = '0;
              res.visit      = 1'b1;
              res.nest_depth = 4'd0;
            end else if (!any_hit) begin
              ended_flag_next = 1'b1;
            end else if (found == DW'(MAX_DEPTH)) begin
              res.fault       = FAULT_TOO_DEEP;
              ended_flag_next = 1'b1;
            end else begin
              top_depth_next = found + DW'(1);
              anc_we         = 1'b1;
              anc_wa         = top_depth_next;
              res.visit      = 1'b1;
              res.nest_depth = 4'(top_depth_next);
            end
            if (res.visit) begin
              res.desc_offset = cur_start;
              res.desc_type   = data_byte;
            end
          end
          // same byte may also be the next length byte
          if (!ended_flag_next && (byte_position == next_start)) begin
            if (data_byte == 8'd0) begin
              res.fault       = FAULT_ZERO_LEN;
              ended_flag_next = 1'b1;
            end else begin
              cur_start_next  = byte_position;
              next_start_next = len_sum[16] ? 16'hFFFF : len_sum[15:0];
              byte_phase_next = PH_TYPE;
              if (last_byte && (byte_position == 16'd0)) begin
                // buffer ends before the root's type byte
                res.visit       = 1'b1;
                res.nest_depth  = 4'd0;
                res.desc_type   = 8'd0;
                res.desc_offset = 16'd0;
              end
            end
          end
        end
      end
      if (byte_position != 16'hFFFF) begin
        byte_position_next = byte_position + 16'd1;
      end
      res.walk_done = ended_flag_next || last_byte;
      if (last_byte) begin
        byte_position_next = '0;
        next_start_next    = '0;
        cur_start_next     = '0;
        byte_phase_next    = PH_LEN;
        top_depth_next     = '0;
        ended_flag_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      next_start    <= '0;
      cur_start     <= '0;
      byte_phase    <= PH_LEN;
      top_depth     <= '0;
      ended_flag    <= 1'b0;
    end else begin
      byte_position <= byte_position_next;
      next_start    <= next_start_next;
      cur_start     <= cur_start_next;
      byte_phase    <= byte_phase_next;
      top_depth     <= top_depth_next;
      ended_flag    <= ended_flag_next;
    end
  end

  // ancestor type stack
  always_ff @(posedge clk) begin
    if (anc_we) begin
      anc[anc_wa] <= data_byte;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (!out_valid || take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (take && skid_valid) begin
      out_q <= skid_q;
    end
  end

  assign visit       = out_q.visit;
  assign desc_offset = out_q.desc_offset;
  assign nest_depth  = out_q.nest_depth;
  assign desc_type   = out_q.desc_type;
  assign walk_done   = out_q.walk_done;
  assign fault       = out_q.fault;

`include "usb_descriptor_tree_walker_top_assert.svh"

  `UDTW_ASSERT_IMP(a_skid_behind_head, clk, rst, skid_valid, out_valid)
  `UDTW_ASSERT_ALWAYS(a_depth_in_range, clk, rst, int'(top_depth) <= MAX_DEPTH)
  `UDTW_ASSERT_IMP(a_fault_ends_walk, clk, rst, out_valid && (out_q.fault != FAULT_NONE), out_q.walk_done)
  `UDTW_ASSERT_NXT(a_last_clears_walk, clk, rst, accept && last_byte, (top_depth == '0) && !ended_flag && (byte_position == '0) && (byte_phase == PH_LEN))

endmodule

@@ tb/sv/udtw_walk_checker.sv @@
`timescale 1ns / 100ps

module udtw_walk_checker
  import udtw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   visit,
  input  logic [15:0]            desc_offset,
  input  logic [3:0]             nest_depth,
  input  logic [7:0]             desc_type,
  input  logic                   walk_done,
  input  logic [1:0]             fault,
  output int                     mismatches,
  output int                     results_owed
);

  // nesting table as last written
  logic [CFG_DATA_W-1:0] nest_tbl [PAIR_REGS];

  // walk state
  logic [15:0] buf_pos;
  logic [15:0] next_start;
  phase_t      walk_phase;
  logic [15:0] cur_start;
  logic [7:0]  anc_type [0:MAX_DEPTH_DEF];
  logic [3:0]  stack_top;
  logic        walk_ended;

  result_t walk_results_q [$];
  result_t got_r;
  result_t want_r;

  initial begin
    mismatches   = 0;
    results_owed = 0;
  end

  function automatic void restart_walk();
    buf_pos    = '0;
    next_start = '0;
    walk_phase = PH_LEN;
    cur_start  = '0;
    for (int i = 0; i <= MAX_DEPTH_DEF; i++) anc_type[i] = '0;
    stack_top  = '0;
    walk_ended = 1'b0;
  endfunction

  // table is scanned in order; an entry with a zero byte ends it
  function automatic logic nesting_ok(input logic [7:0] parent, input logic [7:0] child);
    logic hit;
    logic stop;
    hit  = 1'b0;
    stop = 1'b0;
    for (int k = 0; k < NEST_ENTRIES_DEF && k < PAIR_REGS; k++) begin
      if (!stop) begin
        if (nest_tbl[k][15:8] == 8'h00 || nest_tbl[k][7:0] == 8'h00) begin
          stop = 1'b1;
        end else if (nest_tbl[k] == {parent, child}) begin
          hit  = 1'b1;
          stop = 1'b1;
        end
      end
    end
    return hit;
  endfunction

  function automatic result_t advance_walk(input logic [7:0] b, input logic lst);
    result_t     r;
    int          found;
    int          i;
    logic [16:0] nx;
    r = '0;
    if (!walk_ended) begin
      if (buf_pos >= BUFFER_BYTES_DEF) begin
        r.fault    = FAULT_TOO_LONG;
        walk_ended = 1'b1;
      end else begin
        if (walk_phase == PH_TYPE) begin
          walk_phase = PH_BODY;
          if (cur_start == 16'd0) begin
            anc_type[0]  = b;
            stack_top    = '0;
            r.visit      = 1'b1;
            r.nest_depth = '0;
          end else begin
            found = -1;
            for (i = stack_top; i >= 0 && found < 0; i--) begin
              if (i <= MAX_DEPTH_DEF && nesting_ok(anc_type[i], b)) found = i;
            end
            if (found < 0) begin
              walk_ended = 1'b1;
            end else if (found + 1 > MAX_DEPTH_DEF) begin
              r.fault    = FAULT_TOO_DEEP;
              walk_ended = 1'b1;
            end else begin
              stack_top           = 4'(found + 1);
              anc_type[stack_top] = b;
              r.visit             = 1'b1;
              r.nest_depth        = stack_top;
            end
          end
          if (r.visit) begin
            r.desc_offset = cur_start;
            r.desc_type   = b;
          end
        end
        // the same byte may also be the next length
        if (!walk_ended && buf_pos == next_start) begin
          if (b == 8'h00) begin
            r.fault    = FAULT_ZERO_LEN;
            walk_ended = 1'b1;
          end else begin
            nx         = {1'b0, buf_pos} + 17'(b);
            cur_start  = buf_pos;
            next_start = (nx > 17'h0FFFF) ? 16'hFFFF : nx[15:0];
            walk_phase = PH_TYPE;
            // buffer ends right after the root length byte
            if (lst && buf_pos == 16'd0) begin
              r.visit       = 1'b1;
              r.nest_depth  = '0;
              r.desc_type   = '0;
              r.desc_offset = '0;
            end
          end
        end
      end
    end
    if (buf_pos != 16'hFFFF) buf_pos = buf_pos + 16'd1;
    r.walk_done = walk_ended || lst;
    if (lst) restart_walk();
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      restart_walk();
      nest_tbl = PAIR_RESET;
      walk_results_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got_r.visit       = visit;
        got_r.desc_offset = desc_offset;
        got_r.nest_depth  = nest_depth;
        got_r.desc_type   = desc_type;
        got_r.walk_done   = walk_done;
        got_r.fault       = fault_t'(fault);
        if (walk_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("walk check: result with nothing outstanding: visit %0d offset %0d depth %0d",
                     got_r.visit, got_r.desc_offset, got_r.nest_depth,
                     " type 0x%02h done %0d fault %0d",
                     got_r.desc_type, got_r.walk_done, got_r.fault);
        end else begin
          want_r = walk_results_q.pop_front();
          if (got_r.visit !== want_r.visit || got_r.desc_offset !== want_r.desc_offset ||
              got_r.nest_depth !== want_r.nest_depth || got_r.desc_type !== want_r.desc_type ||
              got_r.walk_done !== want_r.walk_done || got_r.fault !== want_r.fault) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("walk check: expected visit %0d offset %0d depth %0d type 0x%02h",
                       want_r.visit, want_r.desc_offset, want_r.nest_depth, want_r.desc_type,
                       " done %0d fault %0d", want_r.walk_done, want_r.fault);
              $display("walk check: actual   visit %0d offset %0d depth %0d type 0x%02h",
                       got_r.visit, got_r.desc_offset, got_r.nest_depth, got_r.desc_type,
                       " done %0d fault %0d", got_r.walk_done, got_r.fault);
            end
          end
        end
      end
      if (cfg_we && cfg_index < PAIR_REGS) nest_tbl[cfg_index] = cfg_data;
      if (in_valid && !in_stall) walk_results_q.push_back(advance_walk(data_byte, last_byte));
    end
    results_owed = walk_results_q.size();
  end

endmodule

@@ tb/sv/usb_descriptor_tree_walker_top_test.sv @@
`timescale 1ns / 100ps

module usb_descriptor_tree_walker_top_test;
  import udtw_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int TABLE_ROUNDS = 8;
  localparam int ROUND_BYTES  = 140;

  localparam logic [CFG_INDEX_W-1:0] PAIR_IDX [PAIR_REGS] = '{
    REG_NEST_PAIR_A, REG_NEST_PAIR_B, REG_NEST_PAIR_C,
    REG_NEST_PAIR_D, REG_NEST_PAIR_E, REG_NEST_PAIR_F
  };

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_NEST_PAIR_A;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic [7:0]             data_byte = '0;
  logic                   last_byte = 1'b0;
  logic                   out_stall = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic        visit;
  logic [15:0] desc_offset;
  logic [3:0]  nest_depth;
  logic [7:0]  desc_type;
  logic        walk_done;
  logic [1:0]  fault;

  int mismatches;
  int results_owed;

  logic [CFG_DATA_W-1:0] cur_table [PAIR_REGS] = PAIR_RESET;
  logic [7:0]            frame [$];

  int          burst_left      = 0;
  int          sent_bytes      = 0;
  int          buffers_sent    = 0;
  int          idle_cycles     = 0;
  stall_mode_t stall_mode      = STALL_NONE;
  int          stall_mode_left = 0;
  int          stall_phase     = 0;

  always #5 clk = ~clk;

  usb_descriptor_tree_walker_top uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .visit       (visit),
    .desc_offset (desc_offset),
    .nest_depth  (nest_depth),
    .desc_type   (desc_type),
    .walk_done   (walk_done),
    .fault       (fault)
  );

  udtw_walk_checker walk_chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .visit        (visit),
    .desc_offset  (desc_offset),
    .nest_depth   (nest_depth),
    .desc_type    (desc_type),
    .walk_done    (walk_done),
    .fault        (fault),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  // receiver back-pressure, switching between patterns
  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      = stall_mode_t'($urandom_range(STALL_NONE, STALL_HEAVY));
      stall_mode_left = $urandom_range(20, 200);
    end
    stall_mode_left--;
    stall_phase++;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall <= (stall_phase % 3 == 0);
      default:        out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
    buffers_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic load_table();
    for (int r = 0; r < PAIR_REGS; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= PAIR_IDX[r];
      cfg_data  <= cur_table[r];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // descriptor chain that mostly follows the current table
  task automatic build_frame();
    logic [7:0]  lvl [0:15];
    logic [15:0] pr;
    logic [7:0]  ty;
    logic [7:0]  prev_ty;
    logic        prev_one;
    logic        placed;
    logic        stopped;
    int          n_act;
    int          kind;
    int          n_desc;
    int          top_lvl;
    int          len;
    int          cut;
    int          i;
    int          j;
    int          t;
    frame.delete();
    n_act = 0;
    while (n_act < NEST_ENTRIES_DEF && n_act < PAIR_REGS &&
           cur_table[n_act][15:8] != 8'h00 && cur_table[n_act][7:0] != 8'h00) n_act++;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 20)) frame.push_back(8'($urandom));
      return;
    end
    n_desc   = $urandom_range(1, 11);
    top_lvl  = 0;
    prev_one = 1'b0;
    prev_ty  = '0;
    stopped  = 1'b0;
    for (i = 0; i < n_desc && !stopped; i++) begin
      if (i == 0) begin
        ty = (n_act > 0 && $urandom_range(0, 4) != 0) ?
             cur_table[$urandom_range(0, n_act - 1)][15:8] : 8'($urandom_range(1, 255));
        lvl[0]  = ty;
        top_lvl = 0;
      end else begin
        placed = 1'b0;
        if (n_act > 0 && $urandom_range(0, 9) != 0) begin
          for (t = 0; t < 4 && !placed; t++) begin
            pr = cur_table[$urandom_range(0, n_act - 1)];
            for (j = top_lvl; j >= 0 && !placed; j--) begin
              if (lvl[j] == pr[15:8]) begin
                placed       = 1'b1;
                top_lvl      = (j + 1 > 15) ? 15 : j + 1;
                lvl[top_lvl] = pr[7:0];
                ty           = pr[7:0];
              end
            end
          end
        end
        if (!placed) ty = 8'($urandom);
      end
      // after a one-byte descriptor its type byte is this length
      if (prev_one) len = prev_ty;
      else len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 7);
      if (kind == 7 && i == n_desc - 1 && !prev_one) len = 0;
      if (len == 0) begin
        frame.push_back(8'h00);
        repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
        stopped  = 1'b1;
        prev_one = 1'b0;
      end else if (len == 1) begin
        frame.push_back(8'h01);
        prev_one = 1'b1;
        prev_ty  = ty;
      end else begin
        frame.push_back(8'(len));
        frame.push_back(ty);
        repeat (len - 2) frame.push_back(8'($urandom));
        prev_one = 1'b0;
      end
    end
    if (prev_one) frame.push_back(prev_ty);
    // cut short: type byte missing or last descriptor past the end
    if (kind == 8 && frame.size() > 1) begin
      cut = $urandom_range(1, frame.size() - 1);
      while (frame.size() > cut) void'(frame.pop_back());
    end
  endtask

  task automatic pick_table(input int round);
    case (round)
      0: cur_table = PAIR_RESET;
      1: foreach (cur_table[k]) cur_table[k] = 16'h0000;
      2: foreach (cur_table[k]) cur_table[k] = 16'hFFFF;
      3: cur_table = '{16'h1010, 16'h1011, 16'h1110, 16'h0000, 16'h2233, 16'h4455};
      default: begin
        foreach (cur_table[k]) begin
          cur_table[k][15:8] = ($urandom_range(0, 11) == 0) ? 8'h00 :
                               ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
          cur_table[k][7:0]  = ($urandom_range(0, 11) == 0) ? 8'h00 :
                               ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
        end
      end
    endcase
  endtask

  initial begin
    int round_bytes;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed buffers on the reset table
    frame = {8'd5};                      // root length only, type missing
    send_frame();
    frame = {8'd0, 8'h12};               // zero length at the root
    send_frame();
    frame = {8'd1, 8'd2, 8'd4, 8'hAA};   // one-byte root, type doubles as next length
    send_frame();
    frame = {8'd1, 8'd0, 8'h55};         // root visited and zero length on one byte
    send_frame();
    frame = {8'd2, 8'd2, 8'd3};          // later descriptor ends before its type
    send_frame();
    frame = {8'hFF, 8'hFF, 8'h00};       // descriptor reaches past the end
    send_frame();
    frame = {8'd3, 8'd2, 8'd0, 8'd2, 8'd4, 8'd2, 8'd5, 8'd2, 8'h30, 8'd2, 8'h29};
    send_frame();

    for (int round = 0; round < TABLE_ROUNDS; round++) begin
      pick_table(round);
      wait_drained();
      load_table();
      round_bytes = 0;
      while (round_bytes < ROUND_BYTES) begin
        build_frame();
        send_frame();
        round_bytes += frame.size();
      end
    end

    wait_drained();
    repeat (4) @(negedge clk);
    $display("run covered %0d bytes in %0d buffers over %0d nesting tables,",
             sent_bytes, buffers_sent, TABLE_ROUNDS);
    $display("with zero lengths, missing type bytes and descriptors past the end");
    if (mismatches == 0 && results_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/udtw_pkg.sv
rtl/usb_descriptor_tree_walker_top.sv
tb/sv/udtw_walk_checker.sv
tb/sv/usb_descriptor_tree_walker_top_test.sv
